[hw/rtl/pstrm_pkg.sv]
// Package for the per-second traffic rate meter.
// Holds the request and response payload types, the window-level codes and fixed constants.
// Used by the top level and by its port checker.
package pstrm_pkg;

   localparam int SEC_W      = 32;
   localparam int LEN_W      = 18;
   localparam int RATE_W     = 32;
   localparam int SUM_W      = 38;
   localparam int DIV_W      = 35;
   localparam int DIV_DIGITS = 5;
   localparam int DIV_STEPS  = 7;
   localparam int DIV_REM_W  = 3;
   localparam int DIVISOR    = 5;
   localparam int MIN_SHORT  = 3;
   localparam int MIN_TEN    = 12;
   localparam int MIN_FORTY  = 42;
   localparam int WIN_ONE    = 1;
   localparam int WIN_TWO    = 2;
   localparam int WIN_TEN    = 10;
   localparam int WIN_FORTY  = 40;

   typedef enum logic [1:0] {
      UPD_NONE,
      UPD_SHORT,
      UPD_TEN,
      UPD_ALL
   } updated_type;

   typedef struct packed {
      logic [SEC_W-1:0] second;
      logic [LEN_W-1:0] length;
   } req_type;

   typedef struct packed {
      logic [RATE_W-1:0] rate_one;
      logic [RATE_W-1:0] max_one;
      logic [RATE_W-1:0] rate_two;
      logic [RATE_W-1:0] max_two;
      logic [RATE_W-1:0] rate_ten;
      logic [RATE_W-1:0] max_ten;
      logic [RATE_W-1:0] rate_forty;
      logic [RATE_W-1:0] max_forty;
      updated_type       windows_updated;
      logic              dropped;
   } rsp_type;

endpackage

[hw/rtl/per_second_traffic_rate_meter.sv]
// Top level of the per-second traffic rate meter: bucket ring memories and the sequencer.
// Depends on pstrm_pkg for payload types and constants.
//
// Each request transfer carries one packet's second and byte length and yields one response
// transfer with the held 1, 2, 10 and 40 second rates and their maxima. A sequencer drives one
// read port on the bucket ring and one adder, then a divide-by-five unit that retires five
// quotient bits per cycle. A packet that opens a new second sums N buckets and runs D
// divisions, where N is 0, 2, 10 or 40 and D is 0, 1 or 2. A late packet first searches
// back from the newest bucket for a bucket of its second and is marked dropped when none
// matches. The request side is ready only between packets; a finished response waits in
// an output register.
module per_second_traffic_rate_meter
   import pstrm_pkg::*;
#(
   parameter int RING_SLOTS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int SLOT_W = $clog2(RING_SLOTS);
   localparam int CNT_W  = $clog2(RING_SLOTS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SRCH,
      S_SUM,
      S_DIV,
      S_FIN
   } state_type;

   state_type               state_ff;
   logic [SLOT_W-1:0]       newest_ff;
   logic [CNT_W-1:0]        count_ff;
   logic [SEC_W-1:0]        newest_sec_ff;
   logic [SEC_W-1:0]        sec_ff;
   logic [LEN_W-1:0]        len_ff;
   logic [CNT_W-1:0]        k_ff;
   logic                    pend_ff;
   logic [CNT_W-1:0]        pend_idx_ff;
   logic [SLOT_W-1:0]       pend_addr_ff;
   logic [SEC_W-1:0]        rd_sec_ff;
   logic [RATE_W-1:0]       rd_bytes_ff;
   logic [SUM_W-1:0]        acc_ff;
   logic [RATE_W-1:0]       rate1_ff;
   logic [RATE_W:0]         sum2_ff;
   logic [SUM_W-3:0]        sum10_ff;
   logic [SUM_W-1:0]        sum40_ff;
   logic [DIV_W-1:0]        div_num_ff;
   logic [DIV_REM_W-1:0]    div_rem_ff;
   logic [DIV_W-1:0]        div_quo_ff;
   logic [2:0]              div_cnt_ff;
   logic                    div_sel_ff;
   logic [RATE_W-1:0]       rate10_ff;
   logic [RATE_W-1:0]       rate40_ff;
   logic                    dropped_ff;
   logic [RATE_W-1:0]       held_rate_ff [4];
   logic [RATE_W-1:0]       held_max_ff [4];
   logic                    rsp_valid_ff;
   rsp_type                 rsp_data_ff;

   logic [SEC_W-1:0]        sec_mem [RING_SLOTS];
   logic [RATE_W-1:0]       bytes_mem [RING_SLOTS];

   logic                    req_accept;
   logic                    is_new;
   logic [SLOT_W-1:0]       open_slot;
   logic [SLOT_W:0]         back_ext;
   logic [SLOT_W-1:0]       rd_addr;
   logic                    wr_en;
   logic [SLOT_W-1:0]       wr_addr;
   logic [SEC_W-1:0]        wr_sec;
   logic [RATE_W-1:0]       wr_bytes;
   logic                    match;
   updated_type             level;
   logic [CNT_W-1:0]        n_terms;
   logic                    srch_issue;
   logic                    sum_issue;
   logic [SUM_W-1:0]        acc_in;
   logic [DIV_REM_W-1:0]    rem_in;
   logic [DIV_REM_W:0]      div_t;
   logic [DIV_DIGITS-1:0]   digits;
   logic [DIV_W-1:0]        quo_in;
   logic                    out_free;
   logic [RATE_W-1:0]       cand_rate [4];
   logic                    take [4];
   logic [RATE_W-1:0]       rate_in [4];
   logic [RATE_W-1:0]       max_in [4];

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      is_new = (count_ff == '0) || (req_data.second > newest_sec_ff);
      if (count_ff == '0) begin
         open_slot = newest_ff;
      end else if (newest_ff == SLOT_W'(RING_SLOTS - 1)) begin
         open_slot = '0;
      end else begin
         open_slot = newest_ff + SLOT_W'(1);
      end
      back_ext = {1'b0, newest_ff} + (SLOT_W + 1)'(RING_SLOTS)
               - {1'b0, k_ff[SLOT_W-1:0]};
      if (k_ff[SLOT_W-1:0] <= newest_ff) begin
         rd_addr = newest_ff - k_ff[SLOT_W-1:0];
      end else begin
         rd_addr = back_ext[SLOT_W-1:0];
      end
   end

   always_comb begin
      if (count_ff >= CNT_W'(MIN_FORTY)) begin
         level   = UPD_ALL;
         n_terms = CNT_W'(WIN_FORTY);
      end else if (count_ff >= CNT_W'(MIN_TEN)) begin
         level   = UPD_TEN;
         n_terms = CNT_W'(WIN_TEN);
      end else if (count_ff >= CNT_W'(MIN_SHORT)) begin
         level   = UPD_SHORT;
         n_terms = CNT_W'(WIN_TWO);
      end else begin
         level   = UPD_NONE;
         n_terms = '0;
      end
      srch_issue = (k_ff < count_ff);
      sum_issue  = (k_ff <= n_terms);
      match      = (state_ff == S_SRCH) && pend_ff && (rd_sec_ff == sec_ff);
      acc_in     = acc_ff + SUM_W'(rd_bytes_ff);
   end

   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = open_slot;
      wr_sec   = req_data.second;
      wr_bytes = RATE_W'(req_data.length);
      if (req_accept && is_new) begin
         wr_en = 1'b1;
      end else if (match) begin
         wr_en    = 1'b1;
         wr_addr  = pend_addr_ff;
         wr_sec   = sec_ff;
         wr_bytes = rd_bytes_ff + RATE_W'(len_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sec_mem[wr_addr]   <= wr_sec;
         bytes_mem[wr_addr] <= wr_bytes;
      end
      rd_sec_ff   <= sec_mem[rd_addr];
      rd_bytes_ff <= bytes_mem[rd_addr];
   end

   always_comb begin
      rem_in = div_rem_ff;
      digits = '0;
      div_t  = '0;
      for (int i = 0; i < DIV_DIGITS; i++) begin
         div_t = {rem_in, div_num_ff[DIV_W-1-i]};
         if (div_t >= (DIV_REM_W + 1)'(DIVISOR)) begin
            digits[DIV_DIGITS-1-i] = 1'b1;
            rem_in = DIV_REM_W'(div_t - (DIV_REM_W + 1)'(DIVISOR));
         end else begin
            rem_in = div_t[DIV_REM_W-1:0];
         end
      end
      quo_in = {div_quo_ff[DIV_W-DIV_DIGITS-1:0], digits};
   end

   always_comb begin
      cand_rate[0] = rate1_ff;
      cand_rate[1] = sum2_ff[RATE_W:1];
      cand_rate[2] = rate10_ff;
      cand_rate[3] = rate40_ff;
      take[0] = (level != UPD_NONE);
      take[1] = (level != UPD_NONE);
      take[2] = (level == UPD_TEN) || (level == UPD_ALL);
      take[3] = (level == UPD_ALL);
      for (int j = 0; j < 4; j++) begin
         rate_in[j] = take[j] ? cand_rate[j] : held_rate_ff[j];
         max_in[j]  = (take[j] && (cand_rate[j] > held_max_ff[j])) ? cand_rate[j]
                                                                  : held_max_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         newest_ff    <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < 4; j++) begin
            held_rate_ff[j] <= '0;
            held_max_ff[j]  <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  sec_ff     <= req_data.second;
                  len_ff     <= req_data.length;
                  dropped_ff <= 1'b0;
                  pend_ff    <= 1'b0;
                  if (is_new) begin
                     newest_ff     <= open_slot;
                     newest_sec_ff <= req_data.second;
                     if (count_ff < CNT_W'(RING_SLOTS)) begin
                        count_ff <= count_ff + CNT_W'(1);
                     end
                     k_ff     <= CNT_W'(WIN_ONE);
                     acc_ff   <= '0;
                     state_ff <= S_SUM;
                  end else begin
                     k_ff     <= '0;
                     state_ff <= S_SRCH;
                  end
               end
            end
            S_SRCH: begin
               pend_ff      <= srch_issue;
               pend_idx_ff  <= k_ff;
               pend_addr_ff <= rd_addr;
               if (srch_issue) begin
                  k_ff <= k_ff + CNT_W'(1);
               end
               if (pend_ff && (match || (pend_idx_ff == count_ff - CNT_W'(1)))) begin
                  dropped_ff <= !match;
                  pend_ff    <= 1'b0;
                  k_ff       <= CNT_W'(WIN_ONE);
                  acc_ff     <= '0;
                  state_ff   <= S_SUM;
               end
            end
            S_SUM: begin
               if (n_terms == '0) begin
                  state_ff <= S_FIN;
               end else begin
                  pend_ff     <= sum_issue;
                  pend_idx_ff <= k_ff;
                  if (sum_issue) begin
                     k_ff <= k_ff + CNT_W'(1);
                  end
                  if (pend_ff) begin
                     acc_ff <= acc_in;
                     if (pend_idx_ff == CNT_W'(WIN_ONE)) begin
                        rate1_ff <= rd_bytes_ff;
                     end
                     if (pend_idx_ff == CNT_W'(WIN_TWO)) begin
                        sum2_ff <= acc_in[RATE_W:0];
                     end
                     if (pend_idx_ff == CNT_W'(WIN_TEN)) begin
                        sum10_ff <= acc_in[SUM_W-3:0];
                     end
                     if (pend_idx_ff == CNT_W'(WIN_FORTY)) begin
                        sum40_ff <= acc_in;
                     end
                     if (pend_idx_ff == n_terms) begin
                        pend_ff    <= 1'b0;
                        div_cnt_ff <= '0;
                        div_sel_ff <= 1'b0;
                        state_ff   <= (level == UPD_SHORT) ? S_FIN : S_DIV;
                     end
                  end
               end
            end
            S_DIV: begin
               if (div_cnt_ff == '0) begin
                  div_num_ff <= div_sel_ff ? sum40_ff[SUM_W-1:3] : sum10_ff[SUM_W-3:1];
                  div_rem_ff <= '0;
                  div_quo_ff <= '0;
                  div_cnt_ff <= 3'd1;
               end else begin
                  div_num_ff <= div_num_ff << DIV_DIGITS;
                  div_rem_ff <= rem_in;
                  div_quo_ff <= quo_in;
                  if (div_cnt_ff == 3'(DIV_STEPS)) begin
                     div_cnt_ff <= '0;
                     if (div_sel_ff) begin
                        rate40_ff <= quo_in[RATE_W-1:0];
                        state_ff  <= S_FIN;
                     end else begin
                        rate10_ff <= quo_in[RATE_W-1:0];
                        if (level == UPD_ALL) begin
                           div_sel_ff <= 1'b1;
                        end else begin
                           state_ff <= S_FIN;
                        end
                     end
                  end else begin
                     div_cnt_ff <= div_cnt_ff + 3'd1;
                  end
               end
            end
            S_FIN: begin
               if (out_free) begin
                  for (int j = 0; j < 4; j++) begin
                     held_rate_ff[j] <= rate_in[j];
                     held_max_ff[j]  <= max_in[j];
                  end
                  rsp_data_ff.rate_one        <= rate_in[0];
                  rsp_data_ff.max_one         <= max_in[0];
                  rsp_data_ff.rate_two        <= rate_in[1];
                  rsp_data_ff.max_two         <= max_in[1];
                  rsp_data_ff.rate_ten        <= rate_in[2];
                  rsp_data_ff.max_ten         <= max_in[2];
                  rsp_data_ff.rate_forty      <= rate_in[3];
                  rsp_data_ff.max_forty       <= max_in[3];
                  rsp_data_ff.windows_updated <= level;
                  rsp_data_ff.dropped         <= dropped_ff;
                  rsp_valid_ff                <= 1'b1;
                  state_ff                    <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

[hw/rtl/pstrm_checker.sv]
// Port checker for the per-second traffic rate meter, with its bind to the top level.
// Depends on pstrm_pkg for the response type and window-level codes.
module pstrm_checker
   import pstrm_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request side ready right after a transfer");

   a_max_covers_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.max_one >= rsp_data.rate_one
                 && rsp_data.max_two >= rsp_data.rate_two
                 && rsp_data.max_ten >= rsp_data.rate_ten
                 && rsp_data.max_forty >= rsp_data.rate_forty)
      else $error("held maximum below its rate");

   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.windows_updated == UPD_NONE |->
         rsp_data.rate_one == '0 && rsp_data.max_one == '0
         && rsp_data.rate_two == '0 && rsp_data.max_two == '0
         && rsp_data.rate_ten == '0 && rsp_data.max_ten == '0
         && rsp_data.rate_forty == '0 && rsp_data.max_forty == '0)
      else $error("rates set before any window was updated");

endmodule

bind per_second_traffic_rate_meter pstrm_checker u_pstrm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
